@@ rtl/mctdb_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-channel timed debouncer package
// Shared widths, codes and payload types for the debouncer block.
// ----------------------------------------------------------------------------
package mctdb_pkg;

    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_TIME_BITS    = 32;

    localparam int ACTION_W   = 2;
    localparam int PORT_W     = 8;
    localparam int NUM_PORTS  = 2;
    localparam int CHAN_W     = 4;
    localparam int MASK_W     = 16;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DELAY_W-1:0] RST_DEBOUNCE_DELAY = DELAY_W'(20);
    localparam logic [DELAY_W-1:0] RST_POLL_INTERVAL  = DELAY_W'(100);
    localparam logic               RST_ACTIVE_LOW     = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_TAKE   = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_DELAY = 2'd0,
        REG_POLL_INTERVAL  = 2'd1,
        REG_ACTIVE_LOW     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                port_select;
        logic [PORT_W-1:0]   port_data;
        logic [CHAN_W-1:0]   channel;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] held_mask;
        logic [MASK_W-1:0] latch_mask;
        logic              any_press;
        logic              press_taken;
        logic              poll_request;
    } t_out_item;

    typedef struct packed {
        logic [DELAY_W-1:0] debounce_delay;
        logic [DELAY_W-1:0] poll_interval;
        logic               active_low;
    } t_cfg;

endpackage

@@ rtl/mctdb_if.sv @@
// ----------------------------------------------------------------------------
// Multi-channel timed debouncer interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface mctdb_in_if;
    import mctdb_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                port_select;
    logic [PORT_W-1:0]   port_data;
    logic [CHAN_W-1:0]   channel;

    modport source (output valid, action, port_select, port_data, channel, input ready);
    modport sink   (input valid, action, port_select, port_data, channel, output ready);
endinterface

interface mctdb_out_if;
    import mctdb_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] held_mask;
    logic [MASK_W-1:0] latch_mask;
    logic              any_press;
    logic              press_taken;
    logic              poll_request;

    modport source (output valid, held_mask, latch_mask, any_press, press_taken,
                    poll_request, input ready);
    modport sink   (input valid, held_mask, latch_mask, any_press, press_taken,
                    poll_request, output ready);
endinterface

interface mctdb_cfg_if;
    import mctdb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/mctdb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Debouncer configuration registers
// Holds debounce delay, poll interval and polarity; writes by index.
// ----------------------------------------------------------------------------
module mctdb_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mctdb_cfg_if.sink         i_cfg,
    output mctdb_pkg::t_cfg   o_cfg
);
    import mctdb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DEBOUNCE_DELAY: n_cfg.debounce_delay = i_cfg.data[DELAY_W-1:0];
                REG_POLL_INTERVAL:  n_cfg.poll_interval  = i_cfg.data[DELAY_W-1:0];
                REG_ACTIVE_LOW:     n_cfg.active_low     = i_cfg.data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_delay <= RST_DEBOUNCE_DELAY;
            r_cfg.poll_interval  <= RST_POLL_INTERVAL;
            r_cfg.active_low     <= RST_ACTIVE_LOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/mctdb_in_reg.sv @@
// ----------------------------------------------------------------------------
// Debouncer input register
// Captures one input transaction; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module mctdb_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mctdb_in_if.sink             i_in,
    input  logic                 i_take,
    output logic                 o_valid,
    output mctdb_pkg::t_in_item  o_item
);
    import mctdb_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.action      <= i_in.action;
            r_item.port_select <= i_in.port_select;
            r_item.port_data   <= i_in.port_data;
            r_item.channel     <= i_in.channel;
        end
    end

endmodule

@@ rtl/mctdb_core.sv @@
// ----------------------------------------------------------------------------
// Debouncer core
// Channel state, single-pass update per transaction and result register.
// ----------------------------------------------------------------------------
module mctdb_core #(
    parameter int NUM_CHANNELS = mctdb_pkg::DEF_NUM_CHANNELS,
    parameter int TIME_BITS    = mctdb_pkg::DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  mctdb_pkg::t_in_item  i_item,
    input  mctdb_pkg::t_cfg      i_cfg,
    output logic                 o_take,
    mctdb_out_if.source          o_out
);
    import mctdb_pkg::*;

    logic [TIME_BITS-1:0]    r_time;
    logic [TIME_BITS-1:0]    n_time;
    logic [NUM_CHANNELS-1:0] r_raw;
    logic [NUM_CHANNELS-1:0] n_raw;
    logic [NUM_CHANNELS-1:0] r_stable;
    logic [NUM_CHANNELS-1:0] n_stable;
    logic [NUM_CHANNELS-1:0] r_latch;
    logic [NUM_CHANNELS-1:0] n_latch;
    logic [TIME_BITS-1:0]    r_stamp [NUM_CHANNELS];
    logic [TIME_BITS-1:0]    n_stamp [NUM_CHANNELS];
    logic [TIME_BITS-1:0]    r_poll_stamp;
    logic [TIME_BITS-1:0]    n_poll_stamp;
    logic                    r_res_valid;
    t_out_item               r_res;
    t_out_item               n_res;

    logic                    w_fire;

    assign o_take = !r_res_valid || o_out.ready;
    assign w_fire = i_valid && o_take;

    always_comb begin
        logic [TIME_BITS-1:0]           elapsed;
        logic [TIME_BITS-1:0]           tick_time;
        logic                           taken;
        logic                           poll;
        logic [NUM_CHANNELS+MASK_W-1:0] held_ext;
        logic [NUM_CHANNELS+MASK_W-1:0] latch_ext;

        tick_time    = r_time + TIME_BITS'(1);
        n_time       = r_time;
        n_raw        = r_raw;
        n_stable     = r_stable;
        n_latch      = r_latch;
        n_poll_stamp = r_poll_stamp;
        n_stamp      = r_stamp;
        taken        = 1'b0;
        poll         = 1'b0;
        elapsed      = '0;

        unique case (i_item.action)
            ACT_TICK: begin
                n_time = tick_time;
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    elapsed = tick_time - r_stamp[k];
                    if ((r_raw[k] != r_stable[k]) &&
                        (elapsed >= TIME_BITS'(i_cfg.debounce_delay))) begin
                        n_stable[k] = r_raw[k];
                        if (r_raw[k] != i_cfg.active_low) begin
                            n_latch[k] = 1'b1;
                        end
                    end
                end
                if ((tick_time - r_poll_stamp) >= TIME_BITS'(i_cfg.poll_interval)) begin
                    n_poll_stamp = tick_time;
                    poll         = 1'b1;
                end
            end
            ACT_SAMPLE: begin
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    if ((k < NUM_PORTS * PORT_W) &&
                        ((k / PORT_W) == int'(i_item.port_select)) &&
                        (r_raw[k] != i_item.port_data[k % PORT_W])) begin
                        n_raw[k]   = i_item.port_data[k % PORT_W];
                        n_stamp[k] = r_time;
                    end
                end
            end
            ACT_TAKE: begin
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    if (int'(i_item.channel) == k) begin
                        taken      = r_latch[k];
                        n_latch[k] = 1'b0;
                    end
                end
            end
            default: begin
                n_time = r_time;
            end
        endcase

        held_ext  = {{MASK_W{1'b0}}, (i_cfg.active_low ? ~n_stable : n_stable)};
        latch_ext = {{MASK_W{1'b0}}, n_latch};

        n_res.held_mask    = held_ext[MASK_W-1:0];
        n_res.latch_mask   = latch_ext[MASK_W-1:0];
        n_res.any_press    = |n_latch;
        n_res.press_taken  = taken;
        n_res.poll_request = poll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_raw        <= '1;
            r_stable     <= '1;
            r_latch      <= '0;
            r_poll_stamp <= '0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_stamp[k] <= '0;
            end
        end else if (w_fire) begin
            r_time       <= n_time;
            r_raw        <= n_raw;
            r_stable     <= n_stable;
            r_latch      <= n_latch;
            r_poll_stamp <= n_poll_stamp;
            r_stamp      <= n_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_take) begin
            r_res_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_res_valid;
    assign o_out.held_mask    = r_res.held_mask;
    assign o_out.latch_mask   = r_res.latch_mask;
    assign o_out.any_press    = r_res.any_press;
    assign o_out.press_taken  = r_res.press_taken;
    assign o_out.poll_request = r_res.poll_request;

    a_any_press_matches_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_res.any_press == (|r_latch)))
        else $error("any_press disagrees with latch state");

    a_taken_only_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_item.action != ACT_TAKE) |=> !r_res.press_taken)
        else $error("press_taken set outside a take");

    a_poll_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_item.action != ACT_TICK) |=> (!r_res.poll_request && $stable(r_time)))
        else $error("poll or time change outside a tick");

    a_stable_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_item.action != ACT_TICK) |=> $stable(r_stable))
        else $error("stable levels changed outside a tick");

    a_latch_rise_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_item.action != ACT_TICK) |=> ((r_latch & ~$past(r_latch)) == '0))
        else $error("press latch set outside a tick");

endmodule

@@ rtl/multi_channel_timed_debouncer.sv @@
// ----------------------------------------------------------------------------
// Multi-channel timed debouncer
// Timestamp debouncing of port-sampled lines with press latches and polling.
//
// Channel   Dir  Payload                                         Transaction when
// i_in      in   action, port_select, port_data, channel         valid && ready
// o_out     out  held_mask, latch_mask, any_press,               valid && ready
//                press_taken, poll_request
// i_cfg     in   index, data                                     valid && ready
//
// Every transaction produces exactly one result, via the input register and then
// the result register. One transaction per cycle is sustained while o_out is ready;
// the per-channel elapsed-time compares of a tick set the combinational path.
// Reset (i_rst_n low at a clock edge) clears time, latches and stamps and
// restores idle-high raw and stable levels and default register values.
// A stalled o_out holds its result and backs up i_in after one more item.
// ----------------------------------------------------------------------------
module multi_channel_timed_debouncer #(
    parameter int NUM_CHANNELS = mctdb_pkg::DEF_NUM_CHANNELS,
    parameter int TIME_BITS    = mctdb_pkg::DEF_TIME_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mctdb_in_if.sink     i_in,
    mctdb_out_if.source  o_out,
    mctdb_cfg_if.sink    i_cfg
);
    import mctdb_pkg::*;

    t_cfg     w_cfg;
    t_in_item w_item;
    logic     w_item_valid;
    logic     w_take;

    mctdb_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    mctdb_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    mctdb_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_BITS    (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_item_valid),
        .i_item  (w_item),
        .i_cfg   (w_cfg),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Multi-channel timed debouncer testbench
// Drives tick, port sample and take transactions with bursty timing against a
// randomly stalling result sink, across several register settings. A
// scoreboard class predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
    import mctdb_pkg::*;

    localparam int NUM_CH      = DEF_NUM_CHANNELS;
    localparam int TIME_W      = DEF_TIME_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PORT_BIT_W  = $clog2(PORT_W);

    // Codes with no enum member in the package
    localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {RX_FLOW, RX_SLOW, RX_CHOKE} t_rx_mode;

    class debounce_scoreboard;
        logic [DELAY_W-1:0] delay_ms;
        logic [DELAY_W-1:0] poll_ms;
        logic               active_low;
        logic [TIME_W-1:0]  now_ms;
        logic [TIME_W-1:0]  last_poll_ms;
        logic [TIME_W-1:0]  change_at [NUM_CH];
        logic [MASK_W-1:0]  raw_lvl;
        logic [MASK_W-1:0]  stable_lvl;
        logic [MASK_W-1:0]  latches;
        t_out_item          expected_reports [$];
        int                 errors;

        function new();
            delay_ms     = RST_DEBOUNCE_DELAY;
            poll_ms      = RST_POLL_INTERVAL;
            active_low   = RST_ACTIVE_LOW;
            now_ms       = '0;
            last_poll_ms = '0;
            raw_lvl      = '1;
            stable_lvl   = '1;
            latches      = '0;
            errors       = 0;
            foreach (change_at[k]) change_at[k] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DEBOUNCE_DELAY: delay_ms = val;
                REG_POLL_INTERVAL:  poll_ms = val;
                REG_ACTIVE_LOW:     active_low = val[0];
                default: ;
            endcase
        endfunction

        function void note_input(t_in_item it);
            t_out_item rpt;
            int        base;
            rpt = '0;
            case (it.action)
                ACT_TICK: begin
                    now_ms = now_ms + 1'b1;
                    for (int k = 0; k < NUM_CH; k++) begin
                        if (raw_lvl[k] != stable_lvl[k] &&
                            (now_ms - change_at[k]) >= delay_ms) begin
                            stable_lvl[k] = raw_lvl[k];
                            if (raw_lvl[k] ^ active_low)
                                latches[k] = 1'b1;
                        end
                    end
                    if ((now_ms - last_poll_ms) >= poll_ms) begin
                        last_poll_ms = now_ms;
                        rpt.poll_request = 1'b1;
                    end
                end
                ACT_SAMPLE: begin
                    base = it.port_select ? PORT_W : 0;
                    for (int i = 0; i < PORT_W; i++) begin
                        if (base + i < NUM_CH && raw_lvl[base+i] != it.port_data[i]) begin
                            raw_lvl[base+i]   = it.port_data[i];
                            change_at[base+i] = now_ms;
                        end
                    end
                end
                ACT_TAKE: begin
                    if (it.channel < NUM_CH) begin
                        rpt.press_taken      = latches[it.channel];
                        latches[it.channel]  = 1'b0;
                    end
                end
                default: ;
            endcase
            rpt.held_mask  = stable_lvl ^ {MASK_W{active_low}};
            rpt.latch_mask = latches;
            rpt.any_press  = |latches;
            expected_reports.push_back(rpt);
        endfunction

        function int field_diff(string name, logic [MASK_W-1:0] want, logic [MASK_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            errors += field_diff("held_mask", want.held_mask, got.held_mask);
            errors += field_diff("latch_mask", want.latch_mask, got.latch_mask);
            errors += field_diff("any_press", MASK_W'(want.any_press),
                                 MASK_W'(got.any_press));
            errors += field_diff("press_taken", MASK_W'(want.press_taken),
                                 MASK_W'(got.press_taken));
            errors += field_diff("poll_request", MASK_W'(want.poll_request),
                                 MASK_W'(got.poll_request));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mctdb_in_if  in_ch();
    mctdb_out_if out_ch();
    mctdb_cfg_if cfg_ch();

    debounce_scoreboard sb = new();

    logic [PORT_W-1:0] line_lvl [NUM_PORTS];
    bit                hold_off_req;
    int                cycle_count;

    multi_channel_timed_debouncer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        t_in_item  it;
        t_out_item got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready) begin
                it.action      = in_ch.action;
                it.port_select = in_ch.port_select;
                it.port_data   = in_ch.port_data;
                it.channel     = in_ch.channel;
                sb.note_input(it);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.held_mask    = out_ch.held_mask;
                got.latch_mask   = out_ch.latch_mask;
                got.any_press    = out_ch.any_press;
                got.press_taken  = out_ch.press_taken;
                got.poll_request = out_ch.poll_request;
                sb.check_result(got);
            end
        end
    end

    // Result sink: stretches of free flow, light and heavy stalling,
    // plus one long hold-off on request.
    initial begin
        t_rx_mode mode;
        int       stretch;
        mode    = RX_FLOW;
        stretch = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                if (stretch == 0) begin
                    mode    = t_rx_mode'($urandom_range(2));
                    stretch = $urandom_range(8, 64);
                end
                stretch--;
                case (mode)
                    RX_FLOW:  out_ch.ready <= 1'b1;
                    RX_SLOW:  out_ch.ready <= ($urandom_range(3) != 0);
                    default:  out_ch.ready <= ($urandom_range(3) == 0);
                endcase
            end
        end
    end

    function automatic t_in_item item_of(logic [ACTION_W-1:0] act, logic sel,
                                         logic [PORT_W-1:0] data, logic [CHAN_W-1:0] ch);
        t_in_item it;
        it.action      = act;
        it.port_select = sel;
        it.port_data   = data;
        it.channel     = ch;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        in_ch.valid       <= 1'b1;
        in_ch.action      <= it.action;
        in_ch.port_select <= it.port_select;
        in_ch.port_data   <= it.port_data;
        in_ch.channel     <= it.channel;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [DELAY_W-1:0] dly, input logic [DELAY_W-1:0] intv,
                            input logic al);
        drain();
        write_reg(REG_DEBOUNCE_DELAY, dly);
        write_reg(REG_POLL_INTERVAL, intv);
        write_reg(REG_ACTIVE_LOW, CFG_DATA_W'(al));
    endtask

    task automatic random_item(output t_in_item it);
        int          r;
        int          mode;
        logic        sel;
        r   = $urandom_range(99);
        sel = 1'($urandom_range(1));
        if (r < 40) begin
            it = item_of(ACT_TICK, 1'($urandom_range(1)), PORT_W'($urandom_range(255)),
                         CHAN_W'($urandom_range(15)));
        end else if (r < 75) begin
            mode = $urandom_range(9);
            if (mode < 6)
                line_lvl[sel][PORT_BIT_W'($urandom_range(PORT_W-1))] ^= 1'b1;
            else if (mode < 8)
                line_lvl[sel] = PORT_W'($urandom_range(255));
            it = item_of(ACT_SAMPLE, sel, line_lvl[sel], CHAN_W'($urandom_range(15)));
        end else if (r < 96) begin
            it = item_of(ACT_TAKE, sel, PORT_W'($urandom_range(255)),
                         CHAN_W'($urandom_range(NUM_CH-1)));
        end else begin
            it = item_of(ACT_UNUSED, sel, PORT_W'($urandom_range(255)),
                         CHAN_W'($urandom_range(15)));
        end
    endtask

    task automatic run_random(input int count);
        t_in_item it;
        int       sent;
        int       burst;
        int       gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++) begin
                random_item(it);
                send_item(it);
                sent++;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.action       <= ACT_TICK;
        in_ch.port_select  <= 1'b0;
        in_ch.port_data    <= '0;
        in_ch.channel      <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_DEBOUNCE_DELAY;
        cfg_ch.data        <= '0;
        hold_off_req        = 1'b0;
        line_lvl[0]         = '1;
        line_lvl[1]         = '1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Presses, releases, repeated takes, unused action
        set_regs(16'd1, 16'd2, 1'b1);
        send_item(item_of(ACT_TICK, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_SAMPLE, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_SAMPLE, 1'b1, 8'hA5, 4'd15));
        send_item(item_of(ACT_TICK, 1'b1, 8'hFF, 4'd15));
        send_item(item_of(ACT_TICK, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_TAKE, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_TAKE, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_TAKE, 1'b1, 8'hFF, 4'd9));
        send_item(item_of(ACT_TAKE, 1'b0, 8'h00, 4'd15));
        send_item(item_of(ACT_UNUSED, 1'b1, 8'hFF, 4'd15));
        send_item(item_of(ACT_SAMPLE, 1'b0, 8'hFF, 4'd0));
        send_item(item_of(ACT_TICK, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_TICK, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_SAMPLE, 1'b1, 8'hFF, 4'd0));
        send_item(item_of(ACT_TICK, 1'b0, 8'h00, 4'd0));
        in_ch.valid <= 1'b0;

        // Polarity flipped with levels left as they are; zero delay and interval
        set_regs(16'd0, 16'd0, 1'b0);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_item(item_of(ACT_SAMPLE, 1'b1, 8'h5A, 4'd0));
        send_item(item_of(ACT_TICK, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_TAKE, 1'b0, 8'h00, 4'd14));
        send_item(item_of(ACT_SAMPLE, 1'b1, 8'h00, 4'd0));
        send_item(item_of(ACT_TICK, 1'b0, 8'h00, 4'd0));
        send_item(item_of(ACT_TAKE, 1'b0, 8'h00, 4'd9));
        in_ch.valid <= 1'b0;

        set_regs(16'd3, 16'd7, 1'b1);
        hold_off_req = 1'b1;
        run_random(160);
        set_regs(16'd0, 16'd0, 1'b0);
        run_random(140);
        set_regs(16'hFFFF, 16'hFFFF, 1'b1);
        run_random(100);
        set_regs(16'd1, 16'd1, 1'b0);
        run_random(160);
        set_regs(16'd8, 16'd50, 1'b1);
        run_random(180);
        set_regs(16'd2, 16'hFFFF, 1'b0);
        run_random(160);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
